@@ rtl/npc_pkg.sv @@
// Shared constants, types and state codes for the number property classifier.
package npc_pkg;

    localparam int VALUE_BITS  = 10;
    localparam int NUMBER_W    = 10;
    localparam int DIGITS_W    = 31;
    localparam int SUM_W       = VALUE_BITS + 2;
    localparam int OMEGA_W     = 3;
    localparam int BITCNT_W    = $clog2(VALUE_BITS);

    // The divider retires this many restoring steps per clock.
    localparam int DIV_STEPS   = 5;
    localparam int DIV_CYCLES  = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_PAD     = DIV_CYCLES * DIV_STEPS;
    localparam int DIVCNT_W    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELDS_W = 4 + DIGITS_W;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGITS,
        ST_WALK,
        ST_FACTOR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [VALUE_BITS-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [DIGITS_W-1:0] digits;
        logic                sphenic;
        logic                square;
        logic                prime;
        logic                perfect;
    } result_t;

endpackage

@@ rtl/npc_divider.sv @@
// Shared restoring divider giving quotient and remainder, several bits per clock.
module npc_divider
    import npc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [VALUE_BITS-1:0] rem_reg;
    logic [DIV_PAD-1:0]    dvd_reg;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [VALUE_BITS-1:0] dsr_reg;
    logic [DIVCNT_W-1:0]   cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [VALUE_BITS-1:0] src_rem, src_dsr, src_quo;
    logic [DIV_PAD-1:0]    src_dvd;
    logic [VALUE_BITS-1:0] r;
    logic [VALUE_BITS:0]   wide;
    logic [DIV_PAD-1:0]    sh;
    logic [VALUE_BITS-1:0] q;
    logic                  ge;
    logic                  active, last_step;

    // A start request performs its first slice of steps in the same cycle.
    always_comb
    begin
        src_rem = req.start ? '0 : rem_reg;
        src_dvd = req.start ? DIV_PAD'(req.dividend) : dvd_reg;
        src_dsr = req.start ? req.divisor : dsr_reg;
        src_quo = req.start ? '0 : quo_reg;
        r  = src_rem;
        sh = src_dvd;
        q  = src_quo;
        wide = '0;
        ge   = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            wide = {r, sh[DIV_PAD-1]};
            sh   = sh << 1;
            ge   = (wide >= {1'b0, src_dsr});
            if (ge)
            begin
                wide = wide - {1'b0, src_dsr};
            end
            r = wide[VALUE_BITS-1:0];
            q = {q[VALUE_BITS-2:0], ge};
        end
    end

    always_comb
    begin
        active    = req.start || busy_reg;
        last_step = req.start ? (DIV_CYCLES == 1) : (cnt_reg == DIVCNT_W'(DIV_CYCLES - 1));
        busy_next = active && !last_step;
        done_next = active && last_step;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            cnt_next = DIVCNT_W'(1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + DIVCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            rem_reg <= r;
            dvd_reg <= sh;
            quo_reg <= q;
            dsr_reg <= src_dsr;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/npc_core.sv @@
// Sequencer that drives the shared divider through the divisor walk and the factorisation.
module npc_core
    import npc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] in_number,
    output logic                  res_valid,
    input  logic                  res_take,
    output result_t               res,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp
);

    state_t                state_reg, state_next;
    logic                  launch_reg, launch_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] bits_reg, bits_next;
    logic [BITCNT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic [DIGITS_W-1:0]   dig_reg, dig_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] last_reg, last_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  has_div_reg, has_div_next;
    logic                  sq_reg, sq_next;
    logic [OMEGA_W-1:0]    omega_reg, omega_next;
    logic                  rep_reg, rep_next;

    always_comb
    begin
        state_next   = state_reg;
        launch_next  = launch_reg;
        val_next     = val_reg;
        bits_next    = bits_reg;
        bitcnt_next  = bitcnt_reg;
        dig_next     = dig_reg;
        d_next       = d_reg;
        n_next       = n_reg;
        last_next    = last_reg;
        sum_next     = sum_reg;
        has_div_next = has_div_reg;
        sq_next      = sq_reg;
        omega_next   = omega_reg;
        rep_next     = rep_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = val_reg;
        div_req.divisor  = d_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    val_next     = in_number;
                    bits_next    = in_number;
                    bitcnt_next  = BITCNT_W'(VALUE_BITS - 1);
                    dig_next     = '0;
                    sum_next     = '0;
                    has_div_next = 1'b0;
                    sq_next      = 1'b0;
                    omega_next   = '0;
                    rep_next     = 1'b0;
                    last_next    = '0;
                    state_next   = ST_DIGITS;
                end
            end

            ST_DIGITS:
            begin
                // Most significant bit first: times ten, plus the bit.
                dig_next  = (dig_reg << 3) + (dig_reg << 1)
                          + DIGITS_W'(bits_reg[VALUE_BITS-1]);
                bits_next = bits_reg << 1;
                if (bitcnt_reg == '0)
                begin
                    if (val_reg >= VALUE_BITS'(2))
                    begin
                        d_next      = VALUE_BITS'(1);
                        launch_next = 1'b1;
                        state_next  = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    bitcnt_next = bitcnt_reg - BITCNT_W'(1);
                end
            end

            ST_WALK:
            begin
                if (launch_reg)
                begin
                    launch_next   = 1'b0;
                    div_req.start = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        sum_next = sum_reg + SUM_W'(d_reg);
                        if (d_reg >= VALUE_BITS'(2))
                        begin
                            has_div_next = 1'b1;
                        end
                        if (div_rsp.quotient == d_reg)
                        begin
                            sq_next = 1'b1;
                        end
                    end
                    if (d_reg == val_reg - VALUE_BITS'(1))
                    begin
                        n_next      = val_reg;
                        d_next      = VALUE_BITS'(2);
                        launch_next = 1'b1;
                        state_next  = ST_FACTOR;
                    end
                    else
                    begin
                        d_next          = d_reg + VALUE_BITS'(1);
                        div_req.start   = 1'b1;
                        div_req.divisor = d_reg + VALUE_BITS'(1);
                    end
                end
            end

            ST_FACTOR:
            begin
                div_req.dividend = n_reg;
                if (launch_reg)
                begin
                    launch_next   = 1'b0;
                    div_req.start = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        n_next = div_rsp.quotient;
                        if (d_reg == last_reg)
                        begin
                            rep_next = 1'b1;
                        end
                        else
                        begin
                            omega_next = omega_reg + OMEGA_W'(1);
                            last_next  = d_reg;
                        end
                    end
                    else
                    begin
                        d_next = d_reg + VALUE_BITS'(1);
                    end
                    if (n_next == VALUE_BITS'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = n_next;
                        div_req.divisor  = d_next;
                    end
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        bits_reg    <= bits_next;
        bitcnt_reg  <= bitcnt_next;
        dig_reg     <= dig_next;
        d_reg       <= d_next;
        n_reg       <= n_next;
        last_reg    <= last_next;
        sum_reg     <= sum_next;
        has_div_reg <= has_div_next;
        sq_reg      <= sq_next;
        omega_reg   <= omega_next;
        rep_reg     <= rep_next;
    end

    // Sphenic means three distinct prime factors, none of them repeated.
    assign res.perfect = (sum_reg == SUM_W'(val_reg)) && (val_reg != '0);
    assign res.prime   = (val_reg >= VALUE_BITS'(2)) && !has_div_reg;
    assign res.square  = sq_reg || (val_reg == VALUE_BITS'(1));
    assign res.sphenic = (omega_reg == OMEGA_W'(3)) && !rep_reg;
    assign res.digits  = dig_reg;

endmodule

@@ rtl/number_property_classifier.sv @@
// The time from input transfer to result grows with the input value: the walk divides by every
// divisor from 1 to n-1, where n is the input value, and factorising adds further trial divisions.
// One item is in work at a time; each trial division occupies the shared divider until its
// result returns. The next input is taken while a finished result waits at the output.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
module number_property_classifier
    import npc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] number
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] perfect_flag, [1] prime_flag,
                                                   // [2] square_flag, [3] sphenic_flag,
                                                   // [34:4] binary_digits_decimal
);

    div_req_t div_req;
    div_rsp_t div_rsp;
    result_t  core_res;
    logic     core_valid;
    logic     load;

    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg;

    npc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    npc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_number (s_axis_tdata[VALUE_BITS-1:0]),
        .res_valid (core_valid),
        .res_take  (load),
        .res       (core_res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    // The output register is refilled in the same cycle as its transfer completes.
    always_comb
    begin
        load           = core_valid && (!out_valid_reg || m_axis_tready);
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_data_reg};

endmodule

@@ rtl/npc_chk.sv @@
// Port-level assertions for the number property classifier, bound to the top level.
module npc_chk
    import npc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // An accepted item keeps the block busy, so the input closes at once.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after a transfer");

    // A result never appears in the cycle straight after an input transfer.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared too soon after input");

    // A prime is never perfect, square or sphenic.
    a_prime_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |->
        !(m_axis_tdata[0] || m_axis_tdata[2] || m_axis_tdata[3]))
        else $error("prime flag together with another property");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind number_property_classifier npc_chk u_npc_chk (.*);
